// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the scheduler controller nps_ctrl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, held off during reset
`define SVA_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication, held off during reset
`define SVA_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`else

`define SVA_IMPLY(lbl, clk, rst_n, ante, cons)
`define SVA_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/nps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_pkg
// shared types and codes of the non-preemptive priority scheduler
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int PID_W  = 16;
    localparam int PRIO_W = 8;
    localparam int TICK_W = 32;
    localparam int LEFT_W = 16;
    localparam int KIND_W = 3;

    // command codes of an input word
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_ARRIVE = 1'b1;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_CSW    = 3'd0,
        KIND_START  = 3'd1,
        KIND_SLICE  = 3'd2,
        KIND_FINISH = 3'd3,
        KIND_QUEUED = 3'd4,
        KIND_FULL   = 3'd5
    } t_kind;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ARR,
        S_CSW,
        S_START,
        S_SLICE,
        S_FIN
    } t_state;

    // wave travelling down the slot chain
    typedef struct packed {
        logic              active;
        logic              arrive;
        logic              found;
        logic [PID_W-1:0]  pid;
        logic [PRIO_W-1:0] prio;
        logic [TICK_W-1:0] arrival;
        logic [LEFT_W-1:0] left;
    } t_wave;

endpackage

// ----- hdl/nonpreemptive_priority_scheduler.sv -----
// an arrival, or a tick on an idle cpu, runs a wave through all READY_SLOTS slot cells,
//   one cell a cycle, before its first result, if any, is loaded; a tick with a job already
//   running runs no wave and goes straight to its slice result
// input: one word at a time; a new word is taken only once the sequencer is idle again
// reset: synchronous active low; empties the table and leaves the CPU idle
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler
// non-preemptive priority job scheduler built as a chain of table slots
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler #(
    parameter int READY_SLOTS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_cmd,
    input  logic [nps_pkg::PID_W-1:0]   i_pid,
    input  logic [nps_pkg::PRIO_W-1:0]  i_prio,
    input  logic [nps_pkg::TICK_W-1:0]  i_arrival_tick,
    input  logic [nps_pkg::LEFT_W-1:0]  i_burst,
    input  logic [nps_pkg::TICK_W-1:0]  i_now,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [nps_pkg::KIND_W-1:0]  o_kind,
    output logic [nps_pkg::PID_W-1:0]   o_job_id,
    output logic [nps_pkg::LEFT_W-1:0]  o_left_ticks,
    output logic [nps_pkg::TICK_W-1:0]  o_at_tick,
    output logic                        o_last_result
);
    import nps_pkg::*;

    localparam int IDX_W = $clog2(READY_SLOTS);

    t_wave              w_wave [READY_SLOTS+1];
    logic [IDX_W-1:0]   w_idx  [READY_SLOTS+1];
    logic               w_clr_en;
    logic [IDX_W-1:0]   w_clr_idx;

    assign w_idx[0] = '0;

    // sequencer
    nps_ctrl #(
        .SLOTS (READY_SLOTS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_pid          (i_pid),
        .i_prio         (i_prio),
        .i_arrival_tick (i_arrival_tick),
        .i_burst        (i_burst),
        .i_now          (i_now),
        .o_launch       (w_wave[0]),
        .i_tail         (w_wave[READY_SLOTS]),
        .i_tail_idx     (w_idx[READY_SLOTS]),
        .o_clr_en       (w_clr_en),
        .o_clr_idx      (w_clr_idx),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_job_id       (o_job_id),
        .o_left_ticks   (o_left_ticks),
        .o_at_tick      (o_at_tick),
        .o_last_result  (o_last_result)
    );

    // slot chain
    for (genvar g = 0; g < READY_SLOTS; g++) begin : g_slot
        nps_cell #(
            .SLOTS (READY_SLOTS),
            .INDEX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wave    (w_wave[g]),
            .i_idx     (w_idx[g]),
            .i_clr_en  (w_clr_en),
            .i_clr_idx (w_clr_idx),
            .o_wave    (w_wave[g+1]),
            .o_idx     (w_idx[g+1])
        );
    end

endmodule

// ----- hdl/nps_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_cell
// one ready-table slot; inserts an arriving job or keeps the best candidate
// of a dispatch wave and passes the wave on in the next cycle, never later
// ----------------------------------------------------------------------------
module nps_cell #(
    parameter int SLOTS = 16,
    parameter int INDEX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nps_pkg::t_wave              i_wave,
    input  logic [$clog2(SLOTS)-1:0]    i_idx,
    input  logic                        i_clr_en,
    input  logic [$clog2(SLOTS)-1:0]    i_clr_idx,
    output nps_pkg::t_wave              o_wave,
    output logic [$clog2(SLOTS)-1:0]    o_idx
);
    import nps_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    logic               r_valid;
    logic               n_valid;
    logic [PID_W-1:0]   r_pid;
    logic [PRIO_W-1:0]  r_prio;
    logic [TICK_W-1:0]  r_arrival;
    logic [LEFT_W-1:0]  r_left;
    t_wave              r_wave;
    t_wave              n_wave;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic               w_write;
    logic               w_better;

    // ordering: priority, then arrival, then id; strict so earlier slot wins
    always_comb begin
        w_better = !i_wave.found
                || (r_prio < i_wave.prio)
                || ((r_prio == i_wave.prio)
                    && ((r_arrival < i_wave.arrival)
                        || ((r_arrival == i_wave.arrival) && (r_pid < i_wave.pid))));
    end

    // wave handling
    always_comb begin
        n_wave  = i_wave;
        n_idx   = i_idx;
        w_write = 1'b0;
        if (i_wave.active) begin
            if (i_wave.arrive) begin
                if (!i_wave.found && !r_valid) begin
                    w_write      = 1'b1;
                    n_wave.found = 1'b1;
                end
            end else if (r_valid && w_better) begin
                n_wave.found   = 1'b1;
                n_wave.pid     = r_pid;
                n_wave.prio    = r_prio;
                n_wave.arrival = r_arrival;
                n_wave.left    = r_left;
                n_idx          = IDX_W'(INDEX);
            end
        end
    end

    // slot occupancy
    always_comb begin
        n_valid = r_valid;
        if (w_write) begin
            n_valid = 1'b1;
        end else if (i_clr_en && (i_clr_idx == IDX_W'(INDEX))) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_wave  <= '0;
        end else begin
            r_valid <= n_valid;
            r_wave  <= n_wave;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (w_write) begin
            r_pid     <= i_wave.pid;
            r_prio    <= i_wave.prio;
            r_arrival <= i_wave.arrival;
            r_left    <= i_wave.left;
        end
    end

    assign o_wave = r_wave;
    assign o_idx  = r_idx;

endmodule

// ----- hdl/nps_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_ctrl
// command sequencer: launches waves into the slot chain, holds the running
// job and emits result words through an output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nps_ctrl #(
    parameter int SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cmd,
    input  logic [nps_pkg::PID_W-1:0]       i_pid,
    input  logic [nps_pkg::PRIO_W-1:0]      i_prio,
    input  logic [nps_pkg::TICK_W-1:0]      i_arrival_tick,
    input  logic [nps_pkg::LEFT_W-1:0]      i_burst,
    input  logic [nps_pkg::TICK_W-1:0]      i_now,
    output nps_pkg::t_wave                  o_launch,
    input  nps_pkg::t_wave                  i_tail,
    input  logic [$clog2(SLOTS)-1:0]        i_tail_idx,
    output logic                            o_clr_en,
    output logic [$clog2(SLOTS)-1:0]        o_clr_idx,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [nps_pkg::KIND_W-1:0]      o_kind,
    output logic [nps_pkg::PID_W-1:0]       o_job_id,
    output logic [nps_pkg::LEFT_W-1:0]      o_left_ticks,
    output logic [nps_pkg::TICK_W-1:0]      o_at_tick,
    output logic                            o_last_result
);
    import nps_pkg::*;

    t_state             r_state;
    t_state             n_state;
    t_wave              r_launch;
    t_wave              n_launch;
    logic [TICK_W-1:0]  r_now;
    logic [PID_W-1:0]   r_pid;
    logic [LEFT_W-1:0]  r_burst;
    logic               r_placed;
    logic               r_run_valid;
    logic [PID_W-1:0]   r_run_pid;
    logic [LEFT_W-1:0]  r_run_left;
    logic               r_out_valid;
    t_kind              r_kind;
    t_kind              n_kind;
    logic [PID_W-1:0]   r_job;
    logic [PID_W-1:0]   n_job;
    logic [LEFT_W-1:0]  r_left;
    logic [LEFT_W-1:0]  n_left;
    logic [TICK_W-1:0]  r_at;
    logic               r_last;
    logic               n_last;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_load;
    logic               w_tail_done;
    logic               w_dispatch;
    logic [LEFT_W-1:0]  w_dec;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_tail_done = (r_state == S_SCAN) && i_tail.active;
    assign w_dispatch  = w_tail_done && !i_tail.arrive && i_tail.found;
    assign w_dec       = r_run_left - LEFT_W'(r_run_left != '0);

    // slot clear on dispatch
    assign o_clr_en  = w_dispatch;
    assign o_clr_idx = i_tail_idx;

    // wave launch
    always_comb begin
        n_launch.active  = w_in_acc && ((i_cmd == CMD_ARRIVE) || !r_run_valid);
        n_launch.arrive  = (i_cmd == CMD_ARRIVE);
        n_launch.found   = 1'b0;
        n_launch.pid     = i_pid;
        n_launch.prio    = i_prio;
        n_launch.arrival = i_arrival_tick;
        n_launch.left    = i_burst;
    end
    assign o_launch = r_launch;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if ((i_cmd == CMD_ARRIVE) || !r_run_valid) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_SLICE;
                    end
                end
            end
            S_SCAN: begin
                if (i_tail.active) begin
                    if (i_tail.arrive) begin
                        n_state = S_ARR;
                    end else if (i_tail.found) begin
                        n_state = S_CSW;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ARR: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            S_CSW: begin
                if (w_load) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (w_load) begin
                    n_state = S_SLICE;
                end
            end
            S_SLICE: begin
                if (w_load) begin
                    n_state = (w_dec == '0) ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result word selection
    always_comb begin
        w_load = 1'b0;
        n_kind = r_kind;
        n_job  = r_job;
        n_left = r_left;
        n_last = r_last;
        unique case (r_state)
            S_ARR: begin
                w_load = w_out_free;
                n_kind = r_placed ? KIND_QUEUED : KIND_FULL;
                n_job  = r_pid;
                n_left = r_burst;
                n_last = 1'b1;
            end
            S_CSW: begin
                w_load = w_out_free;
                n_kind = KIND_CSW;
                n_job  = r_run_pid;
                n_left = r_run_left;
                n_last = 1'b0;
            end
            S_START: begin
                w_load = w_out_free;
                n_kind = KIND_START;
                n_job  = r_run_pid;
                n_left = r_run_left;
                n_last = 1'b0;
            end
            S_SLICE: begin
                w_load = w_out_free;
                n_kind = KIND_SLICE;
                n_job  = r_run_pid;
                n_left = w_dec;
                n_last = (w_dec != '0);
            end
            S_FIN: begin
                w_load = w_out_free;
                n_kind = KIND_FINISH;
                n_job  = r_run_pid;
                n_left = '0;
                n_last = 1'b1;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= '0;
            r_out_valid <= 1'b0;
            r_run_valid <= 1'b0;
            r_run_pid   <= '0;
            r_run_left  <= '0;
        end else begin
            r_state     <= n_state;
            r_launch    <= n_launch;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // running job
            if (w_dispatch) begin
                r_run_valid <= 1'b1;
                r_run_pid   <= i_tail.pid;
                r_run_left  <= i_tail.left;
            end else if ((r_state == S_SLICE) && w_load) begin
                r_run_left  <= w_dec;
            end else if ((r_state == S_FIN) && w_load) begin
                r_run_valid <= 1'b0;
                r_run_pid   <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_now   <= i_now;
            r_pid   <= i_pid;
            r_burst <= i_burst;
        end
        if (w_tail_done) begin
            r_placed <= i_tail.found;
        end
        // tick held with the word so a new input cannot disturb it
        if (w_load) begin
            r_kind <= n_kind;
            r_job  <= n_job;
            r_left <= n_left;
            r_at   <= r_now;
            r_last <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_job_id      = r_job;
    assign o_left_ticks  = r_left;
    assign o_at_tick     = r_at;
    assign o_last_result = r_last;

    // checks
    `SVA_IMPLY(a_dispatch_cpu_idle, i_clk, i_rst_n, o_clr_en, !r_run_valid)
    `SVA_IMPLY(a_slice_has_job, i_clk, i_rst_n, (r_state == S_SLICE), r_run_valid)
    `SVA_NEXT(a_finish_frees_cpu, i_clk, i_rst_n, (r_state == S_FIN) && w_load, !r_run_valid)
    `SVA_IMPLY(a_slice_last_flag, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_SLICE), o_last_result == (o_left_ticks != '0))

endmodule
